/* hw/rtl/qsdds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature sine DDS package
// Widths, defaults and the full-wave sine table shared by the oscillator.
// ----------------------------------------------------------------------------
package qsdds_pkg;

    localparam int C_PHASE_BITS      = 16;
    localparam int C_TABLE_ADDR_BITS = 8;
    localparam int C_STEP_BITS       = 16;
    localparam int C_CODE_BITS       = 16;
    localparam int C_SLOT_BITS       = 8;
    localparam int C_ROM_DEPTH       = 1 << C_SLOT_BITS;

    // Flipping the sign bit turns two's complement into offset binary.
    localparam logic [C_CODE_BITS-1:0] C_SIGN_FLIP = 16'h8000;

    // One full turn of a 16-bit two's-complement sine.
    localparam logic [C_CODE_BITS-1:0] C_WAVE_ROM [C_ROM_DEPTH] = '{
        16'h0000, 16'h0324, 16'h0647, 16'h096a, 16'h0c8b, 16'h0fab, 16'h12c8, 16'h15e2,
        16'h18f8, 16'h1c0b, 16'h1f19, 16'h2223, 16'h2528, 16'h2826, 16'h2b1f, 16'h2e11,
        16'h30fb, 16'h33de, 16'h36ba, 16'h398c, 16'h3c56, 16'h3f17, 16'h41ce, 16'h447a,
        16'h471c, 16'h49b4, 16'h4c3f, 16'h4ebf, 16'h5133, 16'h539b, 16'h55f5, 16'h5842,
        16'h5a82, 16'h5cb4, 16'h5ed7, 16'h60ec, 16'h62f2, 16'h64e8, 16'h66cf, 16'h68a6,
        16'h6a6d, 16'h6c24, 16'h6dca, 16'h6f5f, 16'h70e2, 16'h7255, 16'h73b5, 16'h7504,
        16'h7641, 16'h776c, 16'h7884, 16'h798a, 16'h7a7d, 16'h7b5d, 16'h7c29, 16'h7ce3,
        16'h7d8a, 16'h7e1d, 16'h7e9d, 16'h7f09, 16'h7f62, 16'h7fa7, 16'h7fd8, 16'h7ff6,
        16'h7fff, 16'h7ff6, 16'h7fd8, 16'h7fa7, 16'h7f62, 16'h7f09, 16'h7e9d, 16'h7e1d,
        16'h7d8a, 16'h7ce3, 16'h7c29, 16'h7b5d, 16'h7a7d, 16'h798a, 16'h7884, 16'h776c,
        16'h7641, 16'h7504, 16'h73b5, 16'h7255, 16'h70e2, 16'h6f5f, 16'h6dca, 16'h6c24,
        16'h6a6d, 16'h68a6, 16'h66cf, 16'h64e8, 16'h62f2, 16'h60ec, 16'h5ed7, 16'h5cb4,
        16'h5a82, 16'h5842, 16'h55f5, 16'h539b, 16'h5133, 16'h4ebf, 16'h4c3f, 16'h49b4,
        16'h471c, 16'h447a, 16'h41ce, 16'h3f17, 16'h3c56, 16'h398c, 16'h36ba, 16'h33de,
        16'h30fb, 16'h2e11, 16'h2b1f, 16'h2826, 16'h2528, 16'h2223, 16'h1f19, 16'h1c0b,
        16'h18f8, 16'h15e2, 16'h12c8, 16'h0fab, 16'h0c8b, 16'h096a, 16'h0647, 16'h0324,
        16'h0000, 16'hfcdc, 16'hf9b9, 16'hf696, 16'hf375, 16'hf055, 16'hed38, 16'hea1e,
        16'he708, 16'he3f5, 16'he0e7, 16'hdddd, 16'hdad8, 16'hd7da, 16'hd4e1, 16'hd1ef,
        16'hcf05, 16'hcc22, 16'hc946, 16'hc674, 16'hc3aa, 16'hc0e9, 16'hbe32, 16'hbb86,
        16'hb8e4, 16'hb64c, 16'hb3c1, 16'hb141, 16'haecd, 16'hac65, 16'haa0b, 16'ha7be,
        16'ha57e, 16'ha34c, 16'ha129, 16'h9f14, 16'h9d0e, 16'h9b18, 16'h9931, 16'h975a,
        16'h9593, 16'h93dc, 16'h9236, 16'h90a1, 16'h8f1e, 16'h8dab, 16'h8c4b, 16'h8afc,
        16'h89bf, 16'h8894, 16'h877c, 16'h8676, 16'h8583, 16'h84a3, 16'h83d7, 16'h831d,
        16'h8276, 16'h81e3, 16'h8163, 16'h80f7, 16'h809e, 16'h8059, 16'h8028, 16'h800a,
        16'h8000, 16'h800a, 16'h8028, 16'h8059, 16'h809e, 16'h80f7, 16'h8163, 16'h81e3,
        16'h8276, 16'h831d, 16'h83d7, 16'h84a3, 16'h8583, 16'h8676, 16'h877c, 16'h8894,
        16'h89bf, 16'h8afc, 16'h8c4b, 16'h8dab, 16'h8f1e, 16'h90a1, 16'h9236, 16'h93dc,
        16'h9593, 16'h975a, 16'h9931, 16'h9b18, 16'h9d0e, 16'h9f14, 16'ha129, 16'ha34c,
        16'ha57e, 16'ha7be, 16'haa0b, 16'hac65, 16'haecd, 16'hb141, 16'hb3c1, 16'hb64c,
        16'hb8e4, 16'hbb86, 16'hbe32, 16'hc0e9, 16'hc3aa, 16'hc674, 16'hc946, 16'hcc22,
        16'hcf05, 16'hd1ef, 16'hd4e1, 16'hd7da, 16'hdad8, 16'hdddd, 16'he0e7, 16'he3f5,
        16'he708, 16'hea1e, 16'hed38, 16'hf055, 16'hf375, 16'hf696, 16'hf9b9, 16'hfcdc
    };

endpackage

/* hw/rtl/quadrature_sine_dds.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature sine DDS
// Phase accumulator feeding a registered-read sine ROM with sine and cosine
// read ports; samples leave as offset-binary DAC words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     i_sample_tick
//  output    out        o_out_valid / i_out_stall   o_sine_code, o_cosine_code
//  config    in         i_cfg_wr_en                 i_cfg_wr_data (phase step)
//
// One transaction per clock is sustained while the output does not stall. Two
// register stages (accumulate and address, then the ROM read) carry an accepted
// tick's result to the output register, which presents it.
// A transaction whose sample_tick is low gives no result and leaves the phase.
// Reset is synchronous: phase and step clear, the pipeline empties.
// A stall on the output holds both stages; the input stalls only when both
// stages are full.
// ----------------------------------------------------------------------------
module quadrature_sine_dds
    import qsdds_pkg::*;
#(
    parameter int PHASE_BITS      = C_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = C_TABLE_ADDR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [C_STEP_BITS-1:0] i_cfg_wr_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_sample_tick,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [C_CODE_BITS-1:0] o_sine_code,
    output logic [C_CODE_BITS-1:0] o_cosine_code
);

    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_TURN =
        TABLE_ADDR_BITS'(1) << (TABLE_ADDR_BITS - 2);

    logic [C_STEP_BITS-1:0]     r_phase_step;
    logic [PHASE_BITS-1:0]      r_phase_word;
    logic [PHASE_BITS-1:0]      n_phase_word;
    logic [TABLE_ADDR_BITS-1:0] sin_addr;
    logic [TABLE_ADDR_BITS-1:0] cos_addr;
    logic [C_SLOT_BITS-1:0]     sin_slot;
    logic [C_SLOT_BITS-1:0]     cos_slot;

    logic                       r_addr_valid;
    logic [C_SLOT_BITS-1:0]     r_sin_slot;
    logic [C_SLOT_BITS-1:0]     r_cos_slot;
    logic                       r_out_valid;
    logic [C_CODE_BITS-1:0]     r_sine;
    logic [C_CODE_BITS-1:0]     r_cosine;

    logic out_advance;
    logic addr_advance;
    logic tick_accept;

    assign out_advance  = !r_out_valid || !i_out_stall;
    assign addr_advance = !r_addr_valid || out_advance;
    assign tick_accept  = i_in_valid && addr_advance && i_sample_tick;

    assign n_phase_word = r_phase_word + PHASE_BITS'(r_phase_step);
    assign sin_addr     = n_phase_word[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign cos_addr     = sin_addr + QUARTER_TURN;

    // Scale the table address onto the 256-sample ROM.
    generate
        if (TABLE_ADDR_BITS == C_SLOT_BITS) begin : g_slot_same
            assign sin_slot = sin_addr;
            assign cos_slot = cos_addr;
        end else if (TABLE_ADDR_BITS < C_SLOT_BITS) begin : g_slot_up
            assign sin_slot = {sin_addr, {(C_SLOT_BITS-TABLE_ADDR_BITS){1'b0}}};
            assign cos_slot = {cos_addr, {(C_SLOT_BITS-TABLE_ADDR_BITS){1'b0}}};
        end else begin : g_slot_down
            assign sin_slot = sin_addr[TABLE_ADDR_BITS-1 -: C_SLOT_BITS];
            assign cos_slot = cos_addr[TABLE_ADDR_BITS-1 -: C_SLOT_BITS];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
        end else if (i_cfg_wr_en) begin
            r_phase_step <= i_cfg_wr_data;
        end
    end

    // Accumulate and form the two ROM addresses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_word <= '0;
            r_addr_valid <= 1'b0;
        end else begin
            if (addr_advance) begin
                r_addr_valid <= tick_accept;
            end
            if (tick_accept) begin
                r_phase_word <= n_phase_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_sin_slot <= sin_slot;
            r_cos_slot <= cos_slot;
        end
    end

    // Synchronous ROM read with the result held in the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_addr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_addr_valid) begin
            r_sine   <= C_WAVE_ROM[r_sin_slot] ^ C_SIGN_FLIP;
            r_cosine <= C_WAVE_ROM[r_cos_slot] ^ C_SIGN_FLIP;
        end
    end

    assign o_in_stall    = !addr_advance;
    assign o_out_valid   = r_out_valid;
    assign o_sine_code   = r_sine;
    assign o_cosine_code = r_cosine;

endmodule
